[sv/nfcs_pkg.sv]
// Package for the NOR flash command sequencer: payload types, codes, job
// descriptor and the beat table of the unlock sequences.
// No dependencies.
`timescale 1ns / 1ps

package nfcs_pkg;

  // Defaults for top-level parameters
  localparam int ADDR_BITS_DEF   = 18;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int BusAddrW = 18;
  localparam int PollW    = 24;
  localparam int StepW    = 3;
  localparam int PaddrW   = 3;

  localparam logic [PollW-1:0] MAX_POLLS_RST = 24'hFFFFFF;

  // Command codes
  localparam logic [1:0] CMD_ERASE   = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Bus operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // Done status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  // Register index of max_polls
  localparam logic REG_MAX_POLLS = 1'b0;

  // Unlock word addresses and data bytes
  localparam logic [BusAddrW-1:0] UNLOCK_A = 18'h05555;
  localparam logic [BusAddrW-1:0] UNLOCK_B = 18'h02AAA;
  localparam logic [15:0] D_AA    = 16'h00AA;
  localparam logic [15:0] D_55    = 16'h0055;
  localparam logic [15:0] D_80    = 16'h0080;
  localparam logic [15:0] D_30    = 16'h0030;
  localparam logic [15:0] D_A0    = 16'h00A0;
  localparam int          DQ6_BIT = 6;

  // Final step index of the erase and program jobs
  localparam logic [StepW-1:0] ERASE_LAST   = 3'd6;
  localparam logic [StepW-1:0] PROGRAM_LAST = 3'd4;

  typedef enum logic [1:0] {
    JOB_ERASE,
    JOB_PROGRAM,
    JOB_SINGLE
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [18:0] byte_offset;
    logic [15:0] program_word;
    logic [15:0] read_data;
  } cmd_payload_t;

  typedef struct packed {
    logic [1:0]          bus_op;
    logic [BusAddrW-1:0] bus_address;
    logic [15:0]         bus_data;
    logic [1:0]          status;
    logic                last;
  } res_payload_t;

  // One queued job: a full unlock sequence or a single result
  typedef struct packed {
    job_kind_e           kind;
    logic [BusAddrW-1:0] addr;
    logic [15:0]         data;
    logic [1:0]          op;
    logic [1:0]          status;
  } job_t;

  // Push request from front to queue
  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

  function automatic res_payload_t wr_beat(logic [BusAddrW-1:0] a, logic [15:0] d);
    res_payload_t r;
    r.bus_op      = OP_WRITE;
    r.bus_address = a;
    r.bus_data    = d;
    r.status      = ST_OK;
    r.last        = 1'b0;
    return r;
  endfunction

  // Result for a given step of a job
  function automatic res_payload_t make_beat(job_t j, logic [StepW-1:0] step);
    res_payload_t r;
    r.bus_op      = OP_READ;
    r.bus_address = j.addr;
    r.bus_data    = '0;
    r.status      = ST_OK;
    r.last        = 1'b1;
    unique case (j.kind)
      JOB_ERASE: begin
        case (step)
          3'd0: r = wr_beat(UNLOCK_A, D_AA);
          3'd1: r = wr_beat(UNLOCK_B, D_55);
          3'd2: r = wr_beat(UNLOCK_A, D_80);
          3'd3: r = wr_beat(UNLOCK_A, D_AA);
          3'd4: r = wr_beat(UNLOCK_B, D_55);
          3'd5: r = wr_beat(j.addr, D_30);
          default: ;
        endcase
      end
      JOB_PROGRAM: begin
        case (step)
          3'd0: r = wr_beat(UNLOCK_A, D_AA);
          3'd1: r = wr_beat(UNLOCK_B, D_55);
          3'd2: r = wr_beat(UNLOCK_A, D_A0);
          3'd3: r = wr_beat(j.addr, j.data);
          default: ;
        endcase
      end
      default: begin
        r.bus_op = j.op;
        r.status = j.status;
      end
    endcase
    return r;
  endfunction

endpackage

[sv/nfcs_stream_if.sv]
// Valid/ready stream interface carrying one payload struct.
// Payload type is a parameter, usually from nfcs_pkg.
`timescale 1ns / 1ps

interface nfcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/nfcs_front.sv]
// Front end: accepts commands and read data, tracks busy and toggle state,
// and pushes one job per producing item into the queue. Uses nfcs_pkg.
`timescale 1ns / 1ps

module nfcs_front #(
  parameter int ADDR_BITS = nfcs_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nfcs_stream_if.sink                  cmd_i,
  input  logic [nfcs_pkg::PollW-1:0]   max_polls_i,
  input  logic                         q_full_i,
  output nfcs_pkg::job_req_t           job_req_o
);

  localparam int AW = nfcs_pkg::BusAddrW;
  localparam logic [AW-1:0] AddrMask =
    (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);

  logic                        busy_q, busy_d;
  logic                        have_first_q, have_first_d;
  logic                        prev_dq6_q, prev_dq6_d;
  logic [nfcs_pkg::PollW-1:0]  poll_q, poll_d, poll_next;
  logic [AW-1:0]               target_q, target_d, new_target;
  logic                        accept, dq6;
  nfcs_pkg::cmd_payload_t      p;

  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign p           = cmd_i.payload;
  assign dq6         = p.read_data[nfcs_pkg::DQ6_BIT];
  assign poll_next   = poll_q + 1'b1;
  assign new_target  = p.byte_offset[18:1] & AddrMask;

  // Classify the item and update the protocol state
  always_comb begin
    busy_d       = busy_q;
    have_first_d = have_first_q;
    prev_dq6_d   = prev_dq6_q;
    poll_d       = poll_q;
    target_d     = target_q;
    job_req_o.push       = 1'b0;
    job_req_o.job.kind   = nfcs_pkg::JOB_SINGLE;
    job_req_o.job.addr   = target_q;
    job_req_o.job.data   = '0;
    job_req_o.job.op     = nfcs_pkg::OP_READ;
    job_req_o.job.status = nfcs_pkg::ST_OK;
    if (accept) begin
      unique case (p.command) inside
        nfcs_pkg::CMD_ERASE, nfcs_pkg::CMD_PROGRAM: begin
          job_req_o.push = 1'b1;
          if (busy_q) begin
            job_req_o.job.op     = nfcs_pkg::OP_DONE;
            job_req_o.job.status = nfcs_pkg::ST_BUSY;
          end else begin
            target_d           = new_target;
            busy_d             = 1'b1;
            have_first_d       = 1'b0;
            prev_dq6_d         = 1'b0;
            poll_d             = '0;
            job_req_o.job.addr = new_target;
            job_req_o.job.data = {p.program_word[7:0], p.program_word[15:8]};
            job_req_o.job.kind = (p.command == nfcs_pkg::CMD_ERASE) ?
                                 nfcs_pkg::JOB_ERASE : nfcs_pkg::JOB_PROGRAM;
          end
        end
        nfcs_pkg::CMD_READ: begin
          if (busy_q) begin
            job_req_o.push = 1'b1;
            if (!have_first_q) begin
              have_first_d = 1'b1;
              prev_dq6_d   = dq6;
            end else if (dq6 == prev_dq6_q) begin
              busy_d           = 1'b0;
              have_first_d     = 1'b0;
              job_req_o.job.op = nfcs_pkg::OP_DONE;
            end else begin
              poll_d = poll_next;
              if (poll_next >= max_polls_i) begin
                busy_d               = 1'b0;
                have_first_d         = 1'b0;
                job_req_o.job.op     = nfcs_pkg::OP_DONE;
                job_req_o.job.status = nfcs_pkg::ST_TIMEOUT;
              end else begin
                prev_dq6_d = dq6;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      have_first_q <= 1'b0;
      prev_dq6_q   <= 1'b0;
      poll_q       <= '0;
      target_q     <= '0;
    end else begin
      busy_q       <= busy_d;
      have_first_q <= have_first_d;
      prev_dq6_q   <= prev_dq6_d;
      poll_q       <= poll_d;
      target_q     <= target_d;
    end
  end

endmodule

[sv/nfcs_queue.sv]
// Short job queue between front and back ends, held in flip-flops.
// Uses nfcs_pkg for the job types.
`timescale 1ns / 1ps

module nfcs_queue #(
  parameter int DEPTH = nfcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfcs_pkg::job_req_t req_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output nfcs_pkg::job_t     head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  nfcs_pkg::job_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = req_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i.job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[sv/nfcs_back.sv]
// Back end: walks the head job step by step and emits one bus request per
// unstalled cycle via an output register. Uses nfcs_pkg, nfcs_stream_if.
`timescale 1ns / 1ps

module nfcs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  nfcs_pkg::job_t         q_head_i,
  output logic                   q_pop_o,
  nfcs_stream_if.source          res_o
);

  logic [nfcs_pkg::StepW-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  nfcs_pkg::res_payload_t     out_q, beat;
  logic                       load;

  assign beat    = nfcs_pkg::make_beat(q_head_i, step_q);
  assign load    = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = load && beat.last;

  // Step through the job and refill the output register
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = beat.last ? '0 : step_q + 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= nfcs_pkg::ERASE_LAST)
    else $error("step counter beyond erase sequence");
  a_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> q_valid_i)
    else $error("job left the queue before its last step");
  a_last_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.last |-> res_o.payload.bus_op != nfcs_pkg::OP_WRITE)
    else $error("write flagged as final result");
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.bus_op == nfcs_pkg::OP_DONE |-> res_o.payload.last)
    else $error("done result not flagged last");
  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> step_q == '0)
    else $error("step counter not cleared after job");
`endif

endmodule

[sv/nor_flash_command_sequencer.sv]
// NOR flash command sequencer, top level: APB register, front end, job queue, back end.
// An accepted item is written to the queue, then loaded into the output register. The
// back end gives one result per cycle while the result side takes them: an erase item
// yields six writes and a read, a program item four writes and a read, others one. The
// front takes an item per cycle while the queue has room. Reset (async, active low)
// clears state, empties the queue and sets max_polls to all ones; no clearing pass.
`timescale 1ns / 1ps

module nor_flash_command_sequencer #(
  parameter int ADDR_BITS   = nfcs_pkg::ADDR_BITS_DEF,
  parameter int QUEUE_DEPTH = nfcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nfcs_stream_if.sink                  cmd_i,
  nfcs_stream_if.source                res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nfcs_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [nfcs_pkg::PollW-1:0] max_polls_q;
  nfcs_pkg::job_req_t         job_req;
  nfcs_pkg::job_t             q_head;
  logic                       q_full, q_valid, q_pop;
  logic                       reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == nfcs_pkg::REG_MAX_POLLS);
  assign prdata  = reg_sel ? {8'd0, max_polls_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_polls_q <= nfcs_pkg::MAX_POLLS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_polls_q <= pwdata[nfcs_pkg::PollW-1:0];
    end
  end

  nfcs_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .max_polls_i (max_polls_q),
    .q_full_i    (q_full),
    .job_req_o   (job_req)
  );

  nfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (job_req),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  nfcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

[sim/nfcs_bus_op_checker.sv]
// Checker for the NOR flash command sequencer: watches the request, result and
// register channels, predicts the bus operations and compares them.
// Depends on nfcs_pkg for payload types and codes.
`timescale 1ns / 1ps

module nfcs_bus_op_checker
  import nfcs_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  logic               cmd_ready_i,
  input  cmd_payload_t       cmd_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  res_payload_t       res_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PaddrW-1:0]  paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [PaddrW-1:0] MaxPollsAddr = {REG_MAX_POLLS, 2'b00};

  // Shadow of the sequencer state and its register
  logic [PollW-1:0]    poll_limit = MAX_POLLS_RST;
  logic                job_busy = 1'b0;
  logic                seen_first_poll = 1'b0;
  logic                last_dq6 = 1'b0;
  logic [PollW-1:0]    toggle_count = '0;
  logic [BusAddrW-1:0] job_address = '0;

  res_payload_t bus_ops_due[$];
  int           mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  function automatic void due_op(logic [1:0] op, logic [BusAddrW-1:0] addr,
                                 logic [15:0] data, logic [1:0] status, logic last);
    res_payload_t r;
    r.bus_op      = op;
    r.bus_address = addr;
    r.bus_data    = data;
    r.status      = status;
    r.last        = last;
    bus_ops_due.push_back(r);
  endfunction

  // Work out the bus operations one request causes and advance the shadow state
  task automatic predict_bus_ops(cmd_payload_t req);
    logic dq6;
    dq6 = req.read_data[DQ6_BIT];
    if (req.command == CMD_ERASE || req.command == CMD_PROGRAM) begin
      if (job_busy) begin
        due_op(OP_DONE, job_address, '0, ST_BUSY, 1'b1);
      end else begin
        job_address = BusAddrW'(req.byte_offset >> 1);
        if (ADDR_BITS < BusAddrW) begin
          job_address &= BusAddrW'((1 << ADDR_BITS) - 1);
        end
        due_op(OP_WRITE, UNLOCK_A, D_AA, ST_OK, 1'b0);
        due_op(OP_WRITE, UNLOCK_B, D_55, ST_OK, 1'b0);
        if (req.command == CMD_ERASE) begin
          due_op(OP_WRITE, UNLOCK_A, D_80, ST_OK, 1'b0);
          due_op(OP_WRITE, UNLOCK_A, D_AA, ST_OK, 1'b0);
          due_op(OP_WRITE, UNLOCK_B, D_55, ST_OK, 1'b0);
          due_op(OP_WRITE, job_address, D_30, ST_OK, 1'b0);
        end else begin
          due_op(OP_WRITE, UNLOCK_A, D_A0, ST_OK, 1'b0);
          due_op(OP_WRITE, job_address,
                 {req.program_word[7:0], req.program_word[15:8]}, ST_OK, 1'b0);
        end
        due_op(OP_READ, job_address, '0, ST_OK, 1'b1);
        job_busy        = 1'b1;
        seen_first_poll = 1'b0;
        last_dq6        = 1'b0;
        toggle_count    = '0;
      end
    end else if (req.command == CMD_READ && job_busy) begin
      if (!seen_first_poll) begin
        // First poll only records DQ6
        seen_first_poll = 1'b1;
        last_dq6        = dq6;
        due_op(OP_READ, job_address, '0, ST_OK, 1'b1);
      end else if (dq6 == last_dq6) begin
        job_busy        = 1'b0;
        seen_first_poll = 1'b0;
        due_op(OP_DONE, job_address, '0, ST_OK, 1'b1);
      end else begin
        toggle_count = toggle_count + 1'b1;
        if (toggle_count >= poll_limit) begin
          job_busy        = 1'b0;
          seen_first_poll = 1'b0;
          due_op(OP_DONE, job_address, '0, ST_TIMEOUT, 1'b1);
        end else begin
          last_dq6 = dq6;
          due_op(OP_READ, job_address, '0, ST_OK, 1'b1);
        end
      end
    end
  endtask

  task automatic check_bus_op(res_payload_t got);
    res_payload_t want;
    if (bus_ops_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing due, bus_op 0x%0h addr 0x%0h",
                                got.bus_op, got.bus_address));
    end else begin
      want = bus_ops_due.pop_front();
      check_field("bus_op", got.bus_op, want.bus_op);
      check_field("bus_address", got.bus_address, want.bus_address);
      check_field("bus_data", got.bus_data, want.bus_data);
      check_field("status", got.status, want.status);
      check_field("last", got.last, want.last);
    end
  endtask

  // Retire results before predicting, so a request and a result on one edge stay in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit      = MAX_POLLS_RST;
      job_busy        = 1'b0;
      seen_first_poll = 1'b0;
      last_dq6        = 1'b0;
      toggle_count    = '0;
      job_address     = '0;
      bus_ops_due.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        check_bus_op(res_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MaxPollsAddr) begin
        poll_limit = pwdata_i[PollW-1:0];
      end
      if (cmd_valid_i && cmd_ready_i) begin
        predict_bus_ops(cmd_i);
      end
      pending_o <= bus_ops_due.size();
    end
  end

endmodule

[sim/tb_nor_flash_command_sequencer.sv]
// Testbench top for the NOR flash command sequencer: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on nfcs_pkg, nfcs_stream_if, the sequencer and nfcs_bus_op_checker.
`timescale 1ns / 1ps

module tb_nor_flash_command_sequencer;
  import nfcs_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 4;
  localparam int StallLimit   = 2000;
  localparam int ChokeCycles  = 80;
  localparam int DrainCycles  = 10;
  localparam int RandomItems  = 115;
  localparam int Phases       = 5;

  localparam logic [1:0]        CMD_UNUSED   = 2'd3;
  localparam logic [PaddrW-1:0] MaxPollsAddr = {REG_MAX_POLLS, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  int choke_left = 0;
  bit choke_done = 1'b0;
  bit choke_req = 1'b0;
  bit steady_flow = 1'b0;

  nfcs_stream_if #(.payload_t(cmd_payload_t)) cmd_if ();
  nfcs_stream_if #(.payload_t(res_payload_t)) res_if ();

  nor_flash_command_sequencer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nfcs_bus_op_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_if.valid),
    .cmd_ready_i  (cmd_if.ready),
    .cmd_i        (cmd_if.payload),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_i        (res_if.payload),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Result side: random back-pressure, one long hold-off, steady stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (choke_left > 0) begin
      res_if.ready <= 1'b0;
      choke_left   <= choke_left - 1;
    end else if (choke_req && !choke_done) begin
      res_if.ready <= 1'b0;
      choke_left   <= ChokeCycles;
      choke_done   <= 1'b1;
    end else begin
      res_if.ready <= steady_flow || ($urandom_range(99) >= 30);
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold until taken
  task automatic send_req(logic [1:0] command, logic [18:0] offset,
                          logic [15:0] word, logic [15:0] rdata);
    cmd_payload_t req;
    req.command      = command;
    req.byte_offset  = offset;
    req.program_word = word;
    req.read_data    = rdata;
    while (!steady_flow && $urandom_range(99) < 30) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= req;
    do @(posedge clk_i); while (!cmd_if.ready);
    items_sent++;
  endtask

  // Wait until every due result is back and the pipeline has drained
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_polls(logic [PollW-1:0] limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxPollsAddr;
    pwdata  <= {8'($urandom), limit};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] poll_word(logic dq6);
    logic [15:0] w;
    w = 16'($urandom);
    w[DQ6_BIT] = dq6;
    return w;
  endfunction

  // One command, maybe a rejected one behind it, then toggling polls and a settling poll
  task automatic run_poll_sequence(int toggles);
    logic       dq6;
    logic [1:0] kind;
    kind = $urandom_range(1) ? CMD_PROGRAM : CMD_ERASE;
    dq6  = 1'($urandom_range(1));
    send_req(kind, 19'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(99) < 15) begin
      send_req($urandom_range(1) ? CMD_PROGRAM : CMD_ERASE, 19'($urandom),
               16'($urandom), 16'($urandom));
    end
    send_req(CMD_READ, 19'($urandom), 16'($urandom), poll_word(dq6));
    repeat (toggles) begin
      dq6 = !dq6;
      send_req(CMD_READ, 19'($urandom), 16'($urandom), poll_word(dq6));
    end
    send_req(CMD_READ, 19'($urandom), 16'($urandom), poll_word(dq6));
  endtask

  task automatic run_random_phase(int quota);
    int stop_at;
    int pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_req(2'($urandom), 19'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 85) begin
        run_poll_sequence($urandom_range(0, 3));
      end else begin
        run_poll_sequence($urandom_range(4, 12));
      end
    end
  endtask

  initial begin
    logic [PollW-1:0] limits [Phases];
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored requests, rejection while busy, ok, timeout, field extremes
    write_max_polls(24'd2);
    send_req(CMD_READ, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_UNUSED, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ERASE, 19'h00000, 16'h0000, 16'h0000);
    send_req(CMD_PROGRAM, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_UNUSED, 19'h00000, 16'h0000, 16'h0000);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'hFFFF);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h0040);
    send_req(CMD_PROGRAM, 19'h7FFFF, 16'h00FF, 16'h0000);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h0000);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h0040);
    send_req(CMD_READ, 19'h7FFFF, 16'hFFFF, 16'hFFBF);
    send_req(CMD_READ, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ERASE, 19'h7FFFE, 16'hFFFF, 16'hFFFF);
    send_req(CMD_ERASE, 19'h55555, 16'h1234, 16'h0000);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'hFFBF);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h0040);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h0040);
    send_req(CMD_PROGRAM, 19'h00001, 16'hA55A, 16'h0000);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h1234);
    send_req(CMD_READ, 19'h00000, 16'h0000, 16'h1234);
    settle();

    // Random phases over several poll limits, extremes and zero among them
    limits = '{24'd1, 24'd0, MAX_POLLS_RST, 24'd3, 24'($urandom_range(2, 8))};
    for (int i = 0; i < Phases; i++) begin
      write_max_polls(limits[i]);
      choke_req   <= (i == 0);
      steady_flow <= (i == 2);
      run_random_phase(RandomItems / Phases);
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
